@@ rtl/ttuv_pkg.sv @@
// Shared types and constants for the triangle tangent block.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package ttuv_pkg;

  localparam int POS_W    = 32;  // input coordinate width
  localparam int DIFF_W   = 33;  // corner difference width
  localparam int PROD_W   = 66;  // product of two differences
  localparam int WIDE_W   = 67;  // difference of two products
  localparam int MAG_W    = 66;  // magnitude of a wide value
  localparam int NORM_TOP = 30;  // largest normalised magnitude lies in [2^29, 2^30)
  localparam int TAN_W    = 16;
  localparam int SRC_W    = 64;  // bit source of the root/divide unit
  localparam int REM_W    = 35;  // partial remainder of the root/divide unit
  localparam int ROOT_W   = 32;
  localparam int STEP_W   = 6;

  localparam int TANGENT_FRAC_BITS_DEF = 14;

  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(SRC_W / 2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ABS,
    S_NORM,
    S_SQ,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WB
  } state_t;

  typedef enum logic [2:0] {
    NORM_R8,
    NORM_R1,
    NORM_L8,
    NORM_L1,
    NORM_DONE
  } norm_op_t;

  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_op_t;

  typedef struct packed {
    logic              start;
    rd_op_t            op;
    logic [STEP_W-1:0] steps;
  } rd_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } rd_rsp_t;

endpackage

@@ rtl/ttuv_mul.sv @@
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on ttuv_pkg.
`timescale 1ns / 1ps

module ttuv_mul import ttuv_pkg::*; (
  input  logic                     clk,
  input  logic signed [DIFF_W-1:0] a,
  input  logic signed [DIFF_W-1:0] b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/ttuv_rootdiv.sv @@
// Iterative shift-subtract unit: integer square root (two bits a step)
// or restoring division (one bit a step). Depends on ttuv_pkg.
`timescale 1ns / 1ps

module ttuv_rootdiv import ttuv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rd_req_t           req,
  input  logic [SRC_W-1:0]  src_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] divisor,
  output rd_rsp_t           rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  rd_op_t            op;
  logic [REM_W-1:0]  rem;
  logic [SRC_W-1:0]  src;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] dvs;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_next;

  always_comb begin
    if (op == RD_SQRT) begin
      shifted = {rem[REM_W-3:0], src[SRC_W-1 -: 2]};
      trial   = {1'b0, root, 2'b01};
    end else begin
      shifted = {rem[REM_W-2:0], src[SRC_W-1]};
      trial   = {{(REM_W-ROOT_W){1'b0}}, dvs};
    end
    ge       = (shifted >= trial);
    rem_next = ge ? (shifted - trial) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      cnt  <= req.steps;
      rem  <= rem_in;
      src  <= src_in;
      root <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= rem_next;
      src  <= (op == RD_SQRT) ? (src << 2) : (src << 1);
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt - STEP_W'(1);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = root;

endmodule

@@ rtl/triangle_tangent_from_uv.sv @@
// Per-triangle unit tangent from texture coordinates, one vertex per transfer.
// First and second corners of a triangle are taken while idle, input ready again next cycle.
// Third corner: products, absolute values, normalisation and sum of squares, then the
// 32-step square root and three divisions on the shared unit; a degenerate triangle
// skips to writeback, which waits while out_stall holds the previous result.
// Reset (synchronous, rst high) clears the corner count, sequencer and output valid.
`timescale 1ns / 1ps

module triangle_tangent_from_uv import ttuv_pkg::*; #(
  parameter int TANGENT_FRAC_BITS = TANGENT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic signed [POS_W-1:0] tex_u,
  input  logic signed [POS_W-1:0] tex_v,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TAN_W-1:0] tan_x,
  output logic signed [TAN_W-1:0] tan_y,
  output logic signed [TAN_W-1:0] tan_z,
  output logic                    degenerate
);

  localparam int DIV_STEPS = TANGENT_FRAC_BITS + 1;
  localparam int DIV_ALIGN = SRC_W - DIV_STEPS;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [POS_W-1:0] v);
    return {v[POS_W-1], v};
  endfunction

  state_t state, state_next;

  logic [1:0]              corner_count;
  logic [POS_W-1:0]        c1_pos [3];
  logic [POS_W-1:0]        c1_tex [2];
  logic [POS_W-1:0]        c2_pos [3];
  logic [POS_W-1:0]        c2_tex [2];
  logic [POS_W-1:0]        in_pos [3];

  logic signed [DIFF_W-1:0] e1 [3];
  logic signed [DIFF_W-1:0] e2 [3];
  logic signed [DIFF_W-1:0] du1, dv1, du2, dv2;

  logic [3:0]               k;
  logic [2:0]               idx;
  logic signed [PROD_W-1:0] hold;
  logic signed [WIDE_W-1:0] w [4];   // det, then tangent x, y, z
  logic signed [WIDE_W-1:0] wide_diff;
  logic [MAG_W-1:0]         mag [3];
  logic                     tneg [3];
  logic                     det_neg;
  logic [MAG_W-1:0]         or_all;
  norm_op_t                 norm_op;
  logic                     degen_now;
  logic [SRC_W-1:0]         sum;
  logic [ROOT_W-1:0]        len;
  logic [1:0]               ci;
  logic [TAN_W-1:0]         res [3];
  logic                     degen_r;

  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  rd_req_t                  rd_req;
  rd_rsp_t                  rd_rsp;
  logic [SRC_W-1:0]         rd_src;
  logic [REM_W-1:0]         rd_rem;
  logic [SRC_W-1:0]         div_num;

  logic in_xfer;
  logic out_free;

  assign in_pos[0] = pos_x;
  assign in_pos[1] = pos_y;
  assign in_pos[2] = pos_z;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx      = 3'(k - 4'd1);

  ttuv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ttuv_rootdiv u_rootdiv (
    .clk     (clk),
    .rst     (rst),
    .req     (rd_req),
    .src_in  (rd_src),
    .rem_in  (rd_rem),
    .divisor (len),
    .rsp     (rd_rsp)
  );

  // datapath helpers
  always_comb begin
    wide_diff = {hold[PROD_W-1], hold} - {prod[PROD_W-1], prod};
    or_all    = mag[0] | mag[1] | mag[2];
    degen_now = (w[0] == '0) || (w[1] == '0 && w[2] == '0 && w[3] == '0);
    if (|or_all[MAG_W-1:NORM_TOP+8]) begin
      norm_op = NORM_R8;
    end else if (|or_all[MAG_W-1:NORM_TOP]) begin
      norm_op = NORM_R1;
    end else if (~|or_all[NORM_TOP-1:NORM_TOP-9]) begin
      norm_op = NORM_L8;
    end else if (!or_all[NORM_TOP-1]) begin
      norm_op = NORM_L1;
    end else begin
      norm_op = NORM_DONE;
    end
    div_num = (SRC_W'(mag[0][NORM_TOP-1:0]) << TANGENT_FRAC_BITS)
            + SRC_W'(len >> 1);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        case (k[2:0])
          3'd0:    begin mul_a = du1; mul_b = dv2;   end
          3'd1:    begin mul_a = dv1; mul_b = du2;   end
          3'd2:    begin mul_a = dv2; mul_b = e1[0]; end
          3'd3:    begin mul_a = dv1; mul_b = e2[0]; end
          3'd4:    begin mul_a = dv2; mul_b = e1[1]; end
          3'd5:    begin mul_a = dv1; mul_b = e2[1]; end
          3'd6:    begin mul_a = dv2; mul_b = e1[2]; end
          default: begin mul_a = dv1; mul_b = e2[2]; end
        endcase
      end
      S_SQ: begin
        case (k[1:0])
          2'd0:    mul_a = {{(DIFF_W-NORM_TOP){1'b0}}, mag[0][NORM_TOP-1:0]};
          2'd1:    mul_a = {{(DIFF_W-NORM_TOP){1'b0}}, mag[1][NORM_TOP-1:0]};
          default: mul_a = {{(DIFF_W-NORM_TOP){1'b0}}, mag[2][NORM_TOP-1:0]};
        endcase
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_xfer && corner_count == 2'd2) state_next = S_MUL;
      S_MUL:       if (k == 4'd8) state_next = S_ABS;
      S_ABS:       state_next = degen_now ? S_WB : S_NORM;
      S_NORM:      if (norm_op == NORM_DONE) state_next = S_SQ;
      S_SQ:        if (k == 4'd3) state_next = S_ROOT_GO;
      S_ROOT_GO:   state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: if (rd_rsp.done) state_next = S_DIV_GO;
      S_DIV_GO:    state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (rd_rsp.done) state_next = (ci == 2'd2) ? S_WB : S_DIV_GO;
      S_WB:        if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    rd_req.start = 1'b0;
    rd_req.op    = RD_SQRT;
    rd_req.steps = SQRT_STEPS;
    rd_src       = sum;
    rd_rem       = '0;
    case (state)
      S_IDLE: in_stall = 1'b0;
      S_ROOT_GO: rd_req.start = 1'b1;
      S_DIV_GO: begin
        rd_req.start = 1'b1;
        rd_req.op    = RD_DIV;
        rd_req.steps = STEP_W'(DIV_STEPS);
        rd_src       = div_num << DIV_ALIGN;
        rd_rem       = REM_W'(div_num >> DIV_STEPS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      corner_count <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        case (corner_count)
          2'd1:    corner_count <= 2'd2;
          2'd2:    corner_count <= 2'd0;
          default: corner_count <= 2'd1;
        endcase
      end
      if (state == S_WB && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k <= (state_next != state) ? 4'd0 : k + 4'd1;

    if (in_xfer) begin
      case (corner_count)
        2'd1: begin
          for (int i = 0; i < 3; i++) c2_pos[i] <= in_pos[i];
          c2_tex[0] <= tex_u;
          c2_tex[1] <= tex_v;
        end
        2'd2: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= sx(c2_pos[i]) - sx(c1_pos[i]);
            e2[i] <= sx(in_pos[i]) - sx(c1_pos[i]);
          end
          du1 <= sx(c2_tex[0]) - sx(c1_tex[0]);
          dv1 <= sx(c2_tex[1]) - sx(c1_tex[1]);
          du2 <= sx(tex_u) - sx(c1_tex[0]);
          dv2 <= sx(tex_v) - sx(c1_tex[1]);
        end
        default: begin
          for (int i = 0; i < 3; i++) c1_pos[i] <= in_pos[i];
          c1_tex[0] <= tex_u;
          c1_tex[1] <= tex_v;
        end
      endcase
    end

    case (state)
      S_MUL: begin
        // even products wait in hold, odd ones complete a difference
        if (k != 4'd0) begin
          if (!idx[0]) begin
            hold <= prod;
          end else begin
            w[idx[2:1]] <= wide_diff;
          end
        end
      end
      S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag[i]  <= w[i+1][WIDE_W-1] ? MAG_W'(-w[i+1]) : w[i+1][MAG_W-1:0];
          tneg[i] <= w[i+1][WIDE_W-1];
        end
        det_neg <= w[0][WIDE_W-1];
        degen_r <= degen_now;
        for (int i = 0; i < 3; i++) res[i] <= '0;
      end
      S_NORM: begin
        sum <= '0;
        for (int i = 0; i < 3; i++) begin
          case (norm_op)
            NORM_R8: mag[i] <= mag[i] >> 8;
            NORM_R1: mag[i] <= mag[i] >> 1;
            NORM_L8: mag[i] <= mag[i] << 8;
            NORM_L1: mag[i] <= mag[i] << 1;
            default: ;
          endcase
        end
      end
      S_SQ: begin
        if (k != 4'd0) sum <= sum + prod[SRC_W-1:0];
      end
      S_ROOT_WAIT: begin
        if (rd_rsp.done) begin
          len <= rd_rsp.result;
          ci  <= 2'd0;
        end
      end
      S_DIV_WAIT: begin
        // rotate components so the next one sits at the front
        if (rd_rsp.done) begin
          res[0]  <= res[1];
          res[1]  <= res[2];
          res[2]  <= (tneg[0] != det_neg) ? TAN_W'(-rd_rsp.result)
                                          : TAN_W'(rd_rsp.result);
          mag[0]  <= mag[1];
          mag[1]  <= mag[2];
          mag[2]  <= mag[0];
          tneg[0] <= tneg[1];
          tneg[1] <= tneg[2];
          tneg[2] <= tneg[0];
          ci      <= ci + 2'd1;
        end
      end
      S_WB: begin
        if (out_free) begin
          tan_x      <= res[0];
          tan_y      <= res[1];
          tan_z      <= res[2];
          degenerate <= degen_r;
        end
      end
      default: ;
    endcase
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    rd_rsp.done |-> (state == S_ROOT_WAIT || state == S_DIV_WAIT))
    else $error("root/divide unit finished with no request outstanding");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (or_all[NORM_TOP-1] && !(|or_all[MAG_W-1:NORM_TOP])))
    else $error("magnitudes left normalisation out of range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_GO) |-> (!len[ROOT_W-1] && len[ROOT_W-2:NORM_TOP-1] != '0))
    else $error("tangent length out of range before division");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (tan_x == '0 && tan_y == '0 && tan_z == '0))
    else $error("degenerate result carries a non-zero tangent");

endmodule
